/* design/i2c_bit_level_master_core_defines.svh */
// ----------------------------------------------------------------------------
// I2C bit-level master: assertion macros
// Clocked assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check a property every clock, ignored while reset is asserted
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property every clock, reset included
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define I2CM_ASSERT(lbl, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C bit-level master: package
// Command codes, phase counts and the bus level table per phase.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_WACK  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    localparam int unsigned ACTION_W    = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PHASE_W     = 5;
    localparam int unsigned TICK_W      = 8;
    localparam logic [7:0]  PHASE_TICKS_RST = 8'd7;
    // read: data bits occupy phases below this, ack bit phases follow
    localparam logic [4:0]  READ_ACK_PHASE  = 5'd16;

    // one result item
    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              ack_missing;
    } res_t;

    // number of phases in each command
    function automatic logic [PHASE_W-1:0] phase_total(input cmd_t cmd);
        logic [PHASE_W-1:0] n;
        begin
            case (cmd)
                CMD_START: n = 5'd3;
                CMD_STOP:  n = 5'd1;
                CMD_WRITE: n = 5'd24;
                CMD_WACK:  n = 5'd3;
                CMD_READ:  n = 5'd19;
                default:   n = 5'd0;
            endcase
            return n;
        end
    endfunction

    // bus levels {scl, sda} at the start of phase p
    function automatic logic [1:0] enter_phase(
        input cmd_t               cmd,
        input logic [PHASE_W-1:0] p,
        input logic [BYTE_W-1:0]  shift,
        input logic               ack_sel,
        input logic               scl,
        input logic               sda
    );
        logic [9:0]         prod;
        logic [2:0]         bidx;
        logic [PHASE_W-1:0] sub;
        logic               dbit;
        logic               scl_n;
        logic               sda_n;
        begin
            // bit index = p / 3 via reciprocal, exact for p below 24
            prod  = 10'(p) * 10'd11;
            bidx  = prod[7:5];
            sub   = p - 5'(6'(bidx) * 6'd3);
            dbit  = shift[3'd7 - bidx];
            scl_n = scl;
            sda_n = sda;
            case (cmd)
                CMD_START:
                begin
                    if (p == 5'd0)
                    begin
                        scl_n = 1'b1;
                        sda_n = 1'b1;
                    end
                    else if (p == 5'd1)
                        sda_n = 1'b0;
                    else
                        scl_n = 1'b0;
                end
                CMD_STOP:
                begin
                    scl_n = 1'b1;
                    sda_n = 1'b0;
                end
                CMD_WRITE:
                begin
                    if (sub == 5'd0)
                        sda_n = dbit;
                    else if (sub == 5'd1)
                        scl_n = 1'b1;
                    else
                    begin
                        scl_n = 1'b0;
                        // release SDA after the last bit
                        sda_n = (bidx == 3'd7) ? 1'b1 : dbit;
                    end
                end
                CMD_WACK:
                begin
                    if (p == 5'd0)
                        sda_n = 1'b1;
                    else if (p == 5'd1)
                        scl_n = 1'b1;
                    else
                        scl_n = 1'b0;
                end
                CMD_READ:
                begin
                    if (p < READ_ACK_PHASE)
                        scl_n = ~p[0];
                    else if (p == READ_ACK_PHASE)
                        sda_n = ~ack_sel;
                    else if (p == READ_ACK_PHASE + 5'd1)
                        scl_n = 1'b1;
                    else
                        scl_n = 1'b0;
                end
                default:
                begin
                    scl_n = scl;
                    sda_n = sda;
                end
            endcase
            return {scl_n, sda_n};
        end
    endfunction

endpackage

/* design/i2c_bit_level_master_core.sv */
// ----------------------------------------------------------------------------
// I2C bit-level master core
// Tick-driven sequencer for start, stop, write byte, wait ack and read byte.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   action, tx_byte, send_ack, sda_in
//   out       source     out_valid / out_stall scl_out, sda_out, busy_res,
//                                              done_res, rx_byte, ack_missing
//   cfg       sink       cfg_wr_en             cfg_wr_data (phase_ticks)
//
// One item per clock while in_stall is low: the sequencer state updates in the
// accept cycle and the result is registered in the result register or skid.
// A two-entry output buffer (result register plus skid) lets the input keep
// flowing while the skid is free; in_stall rises only when both are full.
// Reset clears the sequencer to idle, releases the bus, loads PHASE_TICKS_INIT.
// ----------------------------------------------------------------------------
`include "i2c_bit_level_master_core_defines.svh"

module i2c_bit_level_master_core #(
    parameter logic [7:0] PHASE_TICKS_INIT = i2cm_pkg::PHASE_TICKS_RST
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [7:0]                    cfg_wr_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [i2cm_pkg::ACTION_W-1:0] action,
    input  logic [i2cm_pkg::BYTE_W-1:0]   tx_byte,
    input  logic                          send_ack,
    input  logic                          sda_in,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          scl_out,
    output logic                          sda_out,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [i2cm_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          ack_missing
);
    import i2cm_pkg::*;

    // sequencer state
    logic [7:0]         ptick_reg;
    cmd_t               cmd_reg,   cmd_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_reg,  tick_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic               ackc_reg,  ackc_next;
    logic               scl_reg,   scl_next;
    logic               sda_reg,   sda_next;
    logic [BYTE_W-1:0]  rxb_reg,   rxb_next;
    logic               ackf_reg,  ackf_next;
    logic               done_next;

    // output buffer
    res_t               res_next;
    res_t               main_reg;
    res_t               skid_reg;
    logic               main_valid_reg;
    logic               skid_valid_reg;

    logic               push;
    logic               pop;
    logic [TICK_W-1:0]  len;
    logic [1:0]         lv;
    logic [PHASE_W-1:0] pn;

    assign in_stall = skid_valid_reg;
    assign push     = in_valid & ~in_stall;
    assign pop      = main_valid_reg & ~out_stall;
    // zero phase length acts as one tick
    assign len      = (ptick_reg == '0) ? TICK_W'(1) : ptick_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptick_reg <= PHASE_TICKS_INIT;
        else if (cfg_wr_en)
            ptick_reg <= cfg_wr_data;
    end

    // sequencer next state for the item on the input
    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        ackc_next  = ackc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rxb_next   = rxb_reg;
        ackf_next  = ackf_reg;
        done_next  = 1'b0;
        lv         = 2'b11;
        pn         = '0;

        // take a new command only when idle; the accept tick opens phase 0
        if (cmd_next == CMD_NONE && action inside {[CMD_START:CMD_READ]})
        begin
            cmd_next   = cmd_t'(action);
            phase_next = '0;
            tick_next  = '0;
            shift_next = (cmd_t'(action) == CMD_WRITE) ? tx_byte : '0;
            ackc_next  = send_ack;
            lv         = enter_phase(cmd_next, phase_next, shift_next, ackc_next,
                                     scl_next, sda_next);
            scl_next   = lv[1];
            sda_next   = lv[0];
        end

        // count ticks of the current phase
        if (cmd_next != CMD_NONE)
        begin
            if ({1'b0, tick_next} + 9'd1 >= {1'b0, len})
            begin
                // sample SDA at the end of a high SCL phase
                if (cmd_next == CMD_READ && phase_next < READ_ACK_PHASE && !phase_next[0])
                    shift_next = {shift_next[BYTE_W-2:0], sda_in};
                if (cmd_next == CMD_WACK && phase_next == 5'd1)
                    ackf_next = sda_in;
                pn        = phase_next + 5'd1;
                tick_next = '0;
                if (pn >= phase_total(cmd_next))
                begin
                    if (cmd_next == CMD_STOP)
                        sda_next = 1'b1;
                    if (cmd_next == CMD_READ)
                    begin
                        rxb_next = shift_next;
                        if (ackc_next)
                            sda_next = 1'b1;
                    end
                    cmd_next   = CMD_NONE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
                else
                begin
                    phase_next = pn;
                    lv         = enter_phase(cmd_next, phase_next, shift_next, ackc_next,
                                             scl_next, sda_next);
                    scl_next   = lv[1];
                    sda_next   = lv[0];
                end
            end
            else
                tick_next = tick_next + TICK_W'(1);
        end
    end

    // result for the item
    always_comb
    begin
        res_next.scl         = scl_next;
        res_next.sda         = sda_next;
        res_next.busy        = (cmd_next != CMD_NONE);
        res_next.done        = done_next;
        res_next.rx          = rxb_next;
        res_next.ack_missing = ackf_next;
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_NONE;
            phase_reg <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
            ackc_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rxb_reg   <= '0;
            ackf_reg  <= 1'b0;
        end
        else if (push)
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            ackc_reg  <= ackc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rxb_reg   <= rxb_next;
            ackf_reg  <= ackf_next;
        end
    end

    // output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= res_next;
            else
                main_reg <= res_next;
        end
    end

    assign out_valid   = main_valid_reg;
    assign scl_out     = main_reg.scl;
    assign sda_out     = main_reg.sda;
    assign busy_res    = main_reg.busy;
    assign done_res    = main_reg.done;
    assign rx_byte     = main_reg.rx;
    assign ack_missing = main_reg.ack_missing;

    // checks
    `I2CM_ASSERT_ALWAYS(a_skid_needs_main, !skid_valid_reg || main_valid_reg, "skid full while result register empty")
    `I2CM_ASSERT(a_idle_cleared, cmd_reg != CMD_NONE || (phase_reg == '0 && tick_reg == '0), "idle sequencer with stale phase or tick")
    `I2CM_ASSERT(a_phase_bound, cmd_reg == CMD_NONE || phase_reg < phase_total(cmd_reg), "phase index past end of command")
    `I2CM_ASSERT(a_tick_bound, cmd_reg == CMD_NONE || tick_reg < len || $past(cfg_wr_en), "tick count past phase length")
    `I2CM_ASSERT(a_done_not_busy, !(push && done_next) || cmd_next == CMD_NONE, "command finished but still busy")

endmodule

/* bench/tb_i2c_bit_level_master_core.sv */
// ----------------------------------------------------------------------------
// I2C bit-level master core: testbench
// Sends one tick item per cycle if not held; runs start, stop, write, wait-ack
// and read commands under several phase lengths. Each result is predicted by
// a cycle model of the bus sequencer and checked field by field in order.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master_core;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // action codes with no command behind them
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int unsigned STALL_PCT      = 11;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned RAND_PER_LEN   = 110;

    // how the SDA line is driven while a directed command runs
    typedef enum logic [1:0] {
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM
    } sda_drive_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [7:0]          cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   tx_byte;
    logic                send_ack;
    logic                sda_in;
    logic                out_valid;
    logic                out_stall;
    logic                scl_out;
    logic                sda_out;
    logic                busy_res;
    logic                done_res;
    logic [BYTE_W-1:0]   rx_byte;
    logic                ack_missing;

    // bus sequencer model state
    cmd_t                seq_cmd;
    logic [PHASE_W-1:0]  seq_phase;
    logic [TICK_W-1:0]   seq_tick;
    logic [BYTE_W-1:0]   seq_shift;
    logic                seq_ack_sel;
    logic                bus_scl;
    logic                bus_sda;
    logic [BYTE_W-1:0]   rx_last;
    logic                nack_seen;
    logic [7:0]          phase_len_reg;

    res_t                expected_results[$];
    int unsigned         fail_count;
    int unsigned         report_count;
    int unsigned         result_count;
    int unsigned         quiet_cycles;
    int unsigned         hold_request;
    int unsigned         hold_left;
    bit                  calm;

    i2c_bit_level_master_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .tx_byte     (tx_byte),
        .send_ack    (send_ack),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_out     (scl_out),
        .sda_out     (sda_out),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_missing (ack_missing)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // number of timing phases per command
    function automatic int unsigned phases_of(input cmd_t c);
        case (c)
            CMD_START: return 3;
            CMD_STOP:  return 1;
            CMD_WRITE: return 24;
            CMD_WACK:  return 3;
            CMD_READ:  return 19;
            default:   return 0;
        endcase
    endfunction

    // bus levels driven at the start of the current phase
    function automatic void set_phase_levels();
        int unsigned ph;
        int unsigned bit_no;
        int unsigned sub;
        logic        data_bit;
        ph       = seq_phase;
        bit_no   = (ph / 3) & 7;
        sub      = ph % 3;
        data_bit = seq_shift[7 - bit_no];
        case (seq_cmd)
            CMD_START:
            begin
                if (ph == 0)
                begin
                    bus_scl = 1'b1;
                    bus_sda = 1'b1;
                end
                else if (ph == 1)
                    bus_sda = 1'b0;
                else
                    bus_scl = 1'b0;
            end
            CMD_STOP:
            begin
                bus_scl = 1'b1;
                bus_sda = 1'b0;
            end
            CMD_WRITE:
            begin
                if (sub == 0)
                    bus_sda = data_bit;
                else if (sub == 1)
                    bus_scl = 1'b1;
                else
                begin
                    // SDA let go once the eighth bit has been clocked
                    bus_scl = 1'b0;
                    bus_sda = (bit_no == 7) ? 1'b1 : data_bit;
                end
            end
            CMD_WACK:
            begin
                if (ph == 0)
                    bus_sda = 1'b1;
                else if (ph == 1)
                    bus_scl = 1'b1;
                else
                    bus_scl = 1'b0;
            end
            CMD_READ:
            begin
                if (ph < 16)
                    bus_scl = (ph % 2 == 0);
                else if (ph == 16)
                    bus_sda = ~seq_ack_sel;
                else if (ph == 17)
                    bus_scl = 1'b1;
                else
                    bus_scl = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // advance the sequencer model by one tick and return the bus state after it
    function automatic res_t predict_tick(input logic [2:0] act, input logic [7:0] txb,
                                          input logic ack, input logic sda);
        int unsigned len;
        logic        fin;
        res_t        r;
        len = (phase_len_reg == 8'd0) ? 1 : phase_len_reg;
        fin = 1'b0;
        // a command is taken only while idle
        if (seq_cmd == CMD_NONE && act >= CMD_START && act <= CMD_READ)
        begin
            seq_cmd     = cmd_t'(act);
            seq_phase   = '0;
            seq_tick    = '0;
            seq_shift   = (act == CMD_WRITE) ? txb : 8'h00;
            seq_ack_sel = ack;
            set_phase_levels();
        end
        if (seq_cmd != CMD_NONE)
        begin
            if (int'(seq_tick) + 1 >= len)
            begin
                // sample SDA on the last tick of a high SCL phase
                if (seq_cmd == CMD_READ && seq_phase < 16 && !seq_phase[0])
                    seq_shift = {seq_shift[6:0], sda};
                if (seq_cmd == CMD_WACK && seq_phase == 1)
                    nack_seen = sda;
                seq_tick = '0;
                if (int'(seq_phase) + 1 >= phases_of(seq_cmd))
                begin
                    if (seq_cmd == CMD_STOP)
                        bus_sda = 1'b1;
                    if (seq_cmd == CMD_READ)
                    begin
                        rx_last = seq_shift;
                        if (seq_ack_sel)
                            bus_sda = 1'b1;
                    end
                    seq_cmd   = CMD_NONE;
                    seq_phase = '0;
                    fin       = 1'b1;
                end
                else
                begin
                    seq_phase = seq_phase + 1'b1;
                    set_phase_levels();
                end
            end
            else
                seq_tick = seq_tick + 1'b1;
        end
        r.scl         = bus_scl;
        r.sda         = bus_sda;
        r.busy        = (seq_cmd != CMD_NONE);
        r.done        = fin;
        r.rx          = rx_last;
        r.ack_missing = nack_seen;
        return r;
    endfunction

    function automatic logic pick_sda(input sda_drive_t mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom);
        endcase
    endfunction

    // offer one item, with random idle cycles before it, and log its result
    task automatic send_item(input logic [2:0] act, input logic [7:0] txb,
                             input logic ack, input logic sda);
        res_t exp_r;
        while (!calm && $urandom_range(0, 99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        tx_byte  <= txb;
        send_ack <= ack;
        sda_in   <= sda;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        exp_r = predict_tick(act, txb, ack, sda);
        expected_results.push_back(exp_r);
    endtask

    // drop valid and wait until every result is back
    task automatic hold_sender_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // tick until the sequencer has gone idle
    task automatic settle_idle();
        while (seq_cmd != CMD_NONE)
            send_item(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // change the phase length with the block idle
    task automatic write_phase_len(input logic [7:0] len);
        settle_idle();
        hold_sender_until_drained();
        repeat (3) @(posedge clk);
        cfg_wr_data <= len;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        phase_len_reg  = len;
    endtask

    // issue one command from idle and tick it to completion
    task automatic run_command(input cmd_t cmd, input logic [7:0] txb, input logic ack,
                               input sda_drive_t mode, input bit noisy);
        send_item(cmd, txb, ack, pick_sda(mode));
        while (seq_cmd != CMD_NONE)
            send_item(noisy ? 3'($urandom_range(0, 7)) : CMD_NONE, 8'($urandom),
                      1'($urandom), pick_sda(mode));
    endtask

    // random ticks: mostly commands from idle, anything while busy
    task automatic random_items(input int unsigned n);
        logic [2:0] act;
        for (int unsigned k = 0; k < n; k++)
        begin
            if (seq_cmd != CMD_NONE)
                act = 3'($urandom_range(0, 7));
            else if ($urandom_range(0, 99) < 75)
                act = 3'($urandom_range(CMD_START, CMD_READ));
            else if ($urandom_range(0, 2) == 0)
                act = CMD_NONE;
            else
                act = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
            send_item(act, 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // no-op ticks, including the two unused action codes
    task automatic test_idle_and_spare_codes();
        send_item(CMD_NONE, 8'hFF, 1'b1, 1'b0);
        send_item(ACT_SPARE_LO, 8'h00, 1'b0, 1'b1);
        send_item(ACT_SPARE_HI, 8'h5A, 1'b1, 1'b0);
    endtask

    // every command at least once, with extreme data and both ack outcomes
    task automatic test_each_command();
        run_command(CMD_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        write_phase_len(8'd1);
        run_command(CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
        run_command(CMD_WRITE, 8'h00, 1'b1, SDA_LOW, 1'b0);
        run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
        run_command(CMD_WACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_command(CMD_WACK, 8'h00, 1'b0, SDA_HIGH, 1'b1);
        run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
        run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
        run_command(CMD_READ, 8'h00, 1'b1, SDA_RANDOM, 1'b1);
        run_command(CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        run_command(CMD_STOP, 8'h00, 1'b1, SDA_RANDOM, 1'b1);
    endtask

    // zero length acts as one tick, then the longest phases
    task automatic test_phase_len_extremes();
        write_phase_len(8'd0);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        run_command(CMD_WRITE, 8'h3C, 1'b1, SDA_RANDOM, 1'b1);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        write_phase_len(8'd255);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
    endtask

    // long receiver hold-off while the sender keeps going, then a full pause
    task automatic test_output_hold_off();
        write_phase_len(8'd2);
        calm         = 1'b1;
        hold_request = 60;
        random_items(120);
        calm = 1'b0;
        hold_sender_until_drained();
    endtask

    // random traffic over several phase lengths
    task automatic test_random_traffic();
        write_phase_len(8'd1);
        random_items(RAND_PER_LEN);
        write_phase_len(8'd2);
        random_items(RAND_PER_LEN);
        // a stretch with no idling on either side
        calm = 1'b1;
        write_phase_len(8'd3);
        random_items(RAND_PER_LEN);
        calm = 1'b0;
        write_phase_len(8'd0);
        random_items(RAND_PER_LEN);
        write_phase_len(8'($urandom_range(4, 12)));
        random_items(RAND_PER_LEN);
    endtask

    // main sequence
    initial
    begin
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= 8'h00;
        in_valid     <= 1'b0;
        action       <= CMD_NONE;
        tx_byte      <= 8'h00;
        send_ack     <= 1'b0;
        sda_in       <= 1'b1;
        calm          = 1'b0;
        hold_request  = 0;
        seq_cmd       = CMD_NONE;
        seq_phase     = '0;
        seq_tick      = '0;
        seq_shift     = '0;
        seq_ack_sel   = 1'b0;
        bus_scl       = 1'b1;
        bus_sda       = 1'b1;
        rx_last       = '0;
        nack_seen     = 1'b0;
        phase_len_reg = PHASE_TICKS_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_spare_codes();
        test_each_command();
        test_phase_len_extremes();
        test_output_hold_off();
        test_random_traffic();

        settle_idle();
        hold_sender_until_drained();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("ERROR: %0d results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stall: random, or a counted hold-off when one is requested
    initial
    begin
        out_stall <= 1'b0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request > 0)
            begin
                out_stall    <= 1'b1;
                hold_left     = hold_request - 1;
                hold_request  = 0;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t got;
        res_t exp_r;
        bit   bad;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {scl_out, sda_out, busy_res, done_res, rx_byte, ack_missing};
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("ERROR: unexpected result %p", got);
                end
            end
            else
            begin
                exp_r = expected_results.pop_front();
                bad   = (got.scl !== exp_r.scl) || (got.sda !== exp_r.sda)
                     || (got.busy !== exp_r.busy) || (got.done !== exp_r.done)
                     || (got.rx !== exp_r.rx) || (got.ack_missing !== exp_r.ack_missing);
                if (bad)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                    begin
                        report_count++;
                        // fields: scl sda busy done rx nack
                        $display("ERROR: result %0d exp %b %b %b %b %h %b got %b %b %b %b %h %b",
                                 result_count, exp_r.scl, exp_r.sda, exp_r.busy, exp_r.done,
                                 exp_r.rx, exp_r.ack_missing, got.scl, got.sda, got.busy,
                                 got.done, got.rx, got.ack_missing);
                    end
                end
            end
            result_count++;
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no item moved for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        fail_count   = 0;
        report_count = 0;
        result_count = 0;
        quiet_cycles = 0;
    end

endmodule
